// File: hw/rtl/sdb_pkg.sv
`default_nettype none

package sdb_pkg;

    localparam int DW = 25;
    localparam int SQW = 50;
    localparam int MSQW = 48;
    localparam int RTW = 25;
    localparam int REMW = 27;
    localparam int CXW = 34;
    localparam int AGW = 27;
    localparam int CODEW = 17;
    localparam int CNTW = 5;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int CORDIC_STEPS = 20;
    localparam int GREY_RECIP_W = 18;
    localparam int GREY_SHIFT = 26;

    localparam logic [CNTW-1:0] SQRT_LAST = CNTW'(RTW - 1);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(CODEW - 1);
    localparam logic [CNTW-1:0] ROT_LAST = CNTW'(CORDIC_STEPS - 1);

    localparam logic signed [AGW-1:0] ANG180 = 27'sd11796480;
    localparam logic signed [AGW-1:0] ANG360 = 27'sd23592960;
    localparam logic signed [CXW-1:0] NORM_LIMIT = 34'sd536870912;
    localparam logic [CODEW-1:0] AZI_VERT_CODE = 17'd23040;
    localparam logic [CODEW-1:0] GREY_CAP = 17'd100000;
    // Grey level is the capped difference divided by 500, done as a multiply by
    // the rounded-up reciprocal scaled by 2^26; exact over the capped range.
    localparam logic [GREY_RECIP_W-1:0] GREY_RECIP = 18'd134218;
    localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        RES_BINNED  = 3'd0,
        RES_NEAR    = 3'd1,
        RES_FAR     = 3'd2,
        RES_READ    = 3'd3,
        RES_COUNT   = 3'd4,
        RES_CLEARED = 3'd5
    } res_status_t;

    typedef enum logic [2:0] {
        REG_VIEW_X   = 3'd0,
        REG_VIEW_Y   = 3'd1,
        REG_VIEW_Z   = 3'd2,
        REG_MIN_DIST = 3'd3,
        REG_MAX_HOR  = 3'd4,
        REG_LIMIT    = 3'd5,
        REG_ZEN_STEP = 3'd6,
        REG_AZI_STEP = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SQ_SUM,
        S_SQRT,
        S_CHECK,
        S_NORM,
        S_ROTATE,
        S_ANGLE,
        S_DIV,
        S_INDEX,
        S_BIN_RD,
        S_BIN_UPD,
        S_READ_RD,
        S_READ_CHK,
        S_CLEAR,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_ROW  = 2'd0,
        DIV_COL  = 2'd1,
        DIV_GREY = 2'd2
    } div_sel_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [DW-1:0]  dz;
        logic [15:0]           read_index;
    } item_t;

    typedef struct packed {
        logic [23:0]      min_distance;
        logic [MSQW-1:0]  min_sq;
        logic [MSQW-1:0]  max_sq;
        logic             limit;
        logic [CODEW-1:0] zenith_step;
        logic [CODEW-1:0] azimuth_step;
    } back_cfg_t;

    function automatic logic signed [AGW-1:0] atan_entry(input logic [CNTW-1:0] i);
        logic signed [AGW-1:0] v;
        case (i)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spherical_depth_binning_core.sv
`default_nettype none

// Spherical range-image z-buffer. Each add-point word gives a point in millimetres; the
// block forms its offset from the configured viewpoint, takes range and horizontal range
// with a bit-serial square root, finds zenith and azimuth with one shared 20-step CORDIC
// (with normalising shifts before each), bins both angles with a shared serial divider
// and keeps the minimum range per bin in a single-port RAM by read-modify-write. A clear
// is a sweep over the bin RAM.
// After reset the same sweep runs and no input word is taken until it has finished. A
// four-entry queue lets the input side keep taking words while the engine works, and a
// result register holds a finished word until it is taken.
module spherical_depth_binning_core
    import sdb_pkg::*;
#(
    parameter int ROWS    = 180,
    parameter int COLUMNS = 360
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // point_x, point_y, point_z, read_index
    input  wire logic [87:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bin_index, range_mm, bin_filled, grey_level, empty_upper_count
    output logic [63:0]      m_tdata,
    // status
    output logic [2:0]       m_tuser
);

    logic      q_full, q_empty, q_push, q_pop, init_done;
    item_t     push_item, pop_item;
    back_cfg_t cfg;

    sdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .init_done (init_done),
        .push      (q_push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    sdb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    sdb_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_item    (pop_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: hw/rtl/sdb_ram.sv
`default_nettype none

module sdb_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64800
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sdb_queue.sv
`default_nettype none

module sdb_queue
    import sdb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       empty
);

    item_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full     = (count_reg == (QAW+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: hw/rtl/sdb_front.sv
`default_nettype none

module sdb_front
    import sdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        q_full,
    input  wire logic        init_done,
    output logic             push,
    output item_t            push_item,
    output back_cfg_t        cfg
);

    logic [23:0]     view_x_reg, view_y_reg, view_z_reg;
    logic [23:0]     min_dist_reg, max_hor_reg;
    logic            limit_reg;
    logic [15:0]     zen_step_reg;
    logic [16:0]     azi_step_reg;
    logic [MSQW-1:0] min_sq_reg, max_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg   <= '0;
            view_y_reg   <= '0;
            view_z_reg   <= '0;
            min_dist_reg <= '0;
            max_hor_reg  <= 24'd100000;
            limit_reg    <= 1'b1;
            zen_step_reg <= 16'd256;
            azi_step_reg <= 17'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VIEW_X:   view_x_reg   <= cfg_data;
                REG_VIEW_Y:   view_y_reg   <= cfg_data;
                REG_VIEW_Z:   view_z_reg   <= cfg_data;
                REG_MIN_DIST: min_dist_reg <= cfg_data;
                REG_MAX_HOR:  max_hor_reg  <= cfg_data;
                REG_LIMIT:    limit_reg    <= cfg_data[0];
                REG_ZEN_STEP: zen_step_reg <= cfg_data[15:0];
                REG_AZI_STEP: azi_step_reg <= cfg_data[16:0];
                default:      limit_reg    <= limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        min_sq_reg <= min_dist_reg * min_dist_reg;
        max_sq_reg <= max_hor_reg * max_hor_reg;
    end

    assign s_tready = !q_full && init_done;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_item.cmd        = cmd_t'(s_tuser);
        push_item.dx         = $signed({s_tdata[23], s_tdata[23:0]})
                             - $signed({view_x_reg[23], view_x_reg});
        push_item.dy         = $signed({s_tdata[47], s_tdata[47:24]})
                             - $signed({view_y_reg[23], view_y_reg});
        push_item.dz         = $signed({s_tdata[71], s_tdata[71:48]})
                             - $signed({view_z_reg[23], view_z_reg});
        push_item.read_index = s_tdata[87:72];
    end

    always_comb
    begin
        cfg.min_distance = min_dist_reg;
        cfg.min_sq       = min_sq_reg;
        cfg.max_sq       = max_sq_reg;
        cfg.limit        = limit_reg;
        cfg.zenith_step  = (zen_step_reg == '0) ? CODEW'(1) : CODEW'(zen_step_reg);
        cfg.azimuth_step = (azi_step_reg == '0) ? CODEW'(1) : azi_step_reg;
    end

endmodule

`default_nettype wire

// File: hw/rtl/sdb_back.sv
`default_nettype none

module sdb_back
    import sdb_pkg::*;
#(
    parameter int ROWS    = 180,
    parameter int COLUMNS = 360
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire back_cfg_t   cfg,
    input  wire item_t       q_item,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             init_done,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    localparam int NBINS = ROWS * COLUMNS;
    localparam int UPPER = (ROWS / 2) * COLUMNS;
    localparam int AW = $clog2(NBINS);
    localparam int RW = $clog2(ROWS);
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int EW = $clog2(UPPER + 1);
    localparam int BW = 25;
    localparam int GPW = CODEW + GREY_RECIP_W;

    state_t state_reg, state_next;

    logic signed [DW-1:0]  dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [15:0]           ri_reg, ri_next;
    logic [SQW-1:0]        prod_reg, prod_next, hsq_reg, hsq_next, rsq_reg, rsq_next;
    logic [SQW-1:0]        rad_reg, rad_next;
    logic [RTW-1:0]        root_reg, root_next;
    logic [REMW-1:0]       rem_reg, rem_next;
    logic                  sqrt_h_reg, sqrt_h_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic signed [CXW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [AGW-1:0] cz_reg, cz_next;
    logic                  cord_azi_reg, cord_azi_next;
    logic [CODEW-1:0]      zcode_reg, zcode_next, acode_reg, acode_next;
    logic [CODEW-1:0]      dq_reg, dq_next, drem_reg, drem_next, ddiv_reg, ddiv_next;
    div_sel_t              dsel_reg, dsel_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [AW-1:0]         bidx_reg, bidx_next;
    logic [AW-1:0]         sweep_reg, sweep_next;
    logic [EW-1:0]         empty_reg, empty_next;
    res_status_t           stat_reg, stat_next;
    logic [15:0]           idx_reg, idx_next;
    logic [23:0]           range_reg, range_next;
    logic                  filled_reg, filled_next;
    logic [7:0]            grey_reg, grey_next;
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out_data_reg, out_data_next;
    logic [2:0]            out_user_reg, out_user_next;

    logic                  ram_en, ram_we;
    logic [AW-1:0]         ram_addr;
    logic [BW-1:0]         ram_wdata, ram_rdata;

    logic                  out_free;
    logic signed [DW-1:0]  mul_op;
    logic signed [SQW-1:0] mul_res;
    logic [REMW+1:0]       sq_rem_t, sq_trial;
    logic                  sq_bit;
    logic [RTW-1:0]        sq_root;
    logic [CODEW:0]        dv_rem_t;
    logic                  dv_bit;
    logic [CODEW-1:0]      dv_quot;
    logic signed [CXW-1:0] xs, ys;
    logic signed [AGW-1:0] zen_clamp, azi_wrap;
    logic signed [CXW-1:0] ld_x, ld_y;
    logic                  norm_go;
    logic                  ri_in_range;
    logic                  vertical;
    logic [23:0]           grey_diff;
    logic [CODEW-1:0]      grey_cap;
    logic [GPW-1:0]        grey_prod;

    sdb_ram #(
        .WIDTH (BW),
        .DEPTH (NBINS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign ri_in_range = (32'(ri_reg) < 32'(NBINS));
    assign vertical    = (dx_reg == '0) && (dy_reg == '0);
    assign init_done   = (state_reg != S_INIT);

    // Shared arithmetic steps.
    always_comb
    begin
        case (state_reg)
            S_SQ_Y:  mul_op = dy_reg;
            S_SQ_Z:  mul_op = dz_reg;
            default: mul_op = dx_reg;
        endcase
        mul_res = mul_op * mul_op;

        sq_rem_t = {rem_reg, rad_reg[SQW-1:SQW-2]};
        sq_trial = (REMW+2)'({root_reg, 2'b01});
        sq_bit   = (sq_rem_t >= sq_trial);
        sq_root  = {root_reg[RTW-2:0], sq_bit};

        dv_rem_t = {drem_reg, dq_reg[CODEW-1]};
        dv_bit   = (dv_rem_t >= {1'b0, ddiv_reg});
        dv_quot  = {dq_reg[CODEW-2:0], dv_bit};

        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;

        norm_go = (cx_reg < NORM_LIMIT) && (cx_reg > -NORM_LIMIT)
               && (cy_reg < NORM_LIMIT) && (cy_reg > -NORM_LIMIT);

        zen_clamp = (cz_reg < 0) ? '0 : cz_reg;
        if (cz_reg < 0)
        begin
            azi_wrap = cz_reg + ANG360;
        end
        else if (cz_reg >= ANG360)
        begin
            azi_wrap = cz_reg - ANG360;
        end
        else
        begin
            azi_wrap = cz_reg;
        end

        if (cord_azi_reg)
        begin
            ld_x = CXW'(dy_reg);
            ld_y = CXW'(dx_reg);
        end
        else
        begin
            ld_x = CXW'(dz_reg);
            ld_y = CXW'($signed({1'b0, sq_root}));
        end

        grey_diff = (ram_rdata[23:0] > cfg.min_distance)
                  ? ram_rdata[23:0] - cfg.min_distance : '0;
        grey_cap  = (grey_diff > 24'(GREY_CAP)) ? GREY_CAP : grey_diff[CODEW-1:0];
        grey_prod = GPW'(dq_reg) * GPW'(GREY_RECIP);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (sweep_reg == AW'(NBINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_item.cmd)
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_ADD:   state_next = S_SQ_X;
                        CMD_READ:  state_next = S_READ_RD;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_SQ_X:   state_next = S_SQ_Y;
            S_SQ_Y:   state_next = S_SQ_Z;
            S_SQ_Z:   state_next = S_SQ_SUM;
            S_SQ_SUM: state_next = S_SQRT;
            S_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sqrt_h_reg ? S_NORM : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((rsq_reg == '0) || (rsq_reg < SQW'(cfg.min_sq)))
                begin
                    state_next = S_OUT;
                end
                else if (cfg.limit && (hsq_reg > SQW'(cfg.max_sq)))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SQRT;
                end
            end
            S_NORM:
            begin
                if (!norm_go)
                begin
                    state_next = S_ROTATE;
                end
            end
            S_ROTATE:
            begin
                if (cnt_reg == ROT_LAST)
                begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                if (!cord_azi_reg && !vertical)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (dsel_reg == DIV_GREY)
                begin
                    state_next = S_OUT;
                end
                else if (cnt_reg == '0)
                begin
                    case (dsel_reg)
                        DIV_ROW:  state_next = S_DIV;
                        default:  state_next = S_INDEX;
                    endcase
                end
            end
            S_INDEX:   state_next = S_BIN_RD;
            S_BIN_RD:  state_next = S_BIN_UPD;
            S_BIN_UPD: state_next = S_OUT;
            S_READ_RD: state_next = ri_in_range ? S_READ_CHK : S_OUT;
            S_READ_CHK:
            begin
                state_next = ram_rdata[BW-1] ? S_DIV : S_OUT;
            end
            S_CLEAR:
            begin
                if (sweep_reg == AW'(NBINS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = bidx_reg;
        ram_wdata = {1'b1, range_reg};
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = sweep_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                q_pop = !q_empty;
            end
            S_BIN_RD:
            begin
                ram_en = 1'b1;
            end
            S_BIN_UPD:
            begin
                ram_en = !ram_rdata[BW-1] || (range_reg < ram_rdata[23:0]);
                ram_we = 1'b1;
            end
            S_READ_RD:
            begin
                ram_en   = ri_in_range;
                ram_addr = AW'(ri_reg);
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        ri_next        = ri_reg;
        prod_next      = prod_reg;
        hsq_next       = hsq_reg;
        rsq_next       = rsq_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        sqrt_h_next    = sqrt_h_reg;
        cnt_next       = cnt_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        cord_azi_next  = cord_azi_reg;
        zcode_next     = zcode_reg;
        acode_next     = acode_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        ddiv_next      = ddiv_reg;
        dsel_next      = dsel_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        bidx_next      = bidx_reg;
        sweep_next     = sweep_reg;
        empty_next     = empty_reg;
        stat_next      = stat_reg;
        idx_next       = idx_reg;
        range_next     = range_reg;
        filled_next    = filled_reg;
        grey_next      = grey_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        case (state_reg)
            S_INIT:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE:
            begin
                dx_next     = q_item.dx;
                dy_next     = q_item.dy;
                dz_next     = q_item.dz;
                ri_next     = q_item.read_index;
                sweep_next  = '0;
                idx_next    = '0;
                range_next  = '0;
                filled_next = 1'b0;
                grey_next   = '0;
                case (q_item.cmd)
                    CMD_CLEAR: stat_next = RES_CLEARED;
                    CMD_ADD:   stat_next = RES_BINNED;
                    CMD_READ:  stat_next = RES_READ;
                    default:   stat_next = RES_COUNT;
                endcase
            end
            S_SQ_X:
            begin
                prod_next = $unsigned(mul_res);
            end
            S_SQ_Y:
            begin
                hsq_next  = prod_reg;
                prod_next = $unsigned(mul_res);
            end
            S_SQ_Z:
            begin
                hsq_next  = hsq_reg + prod_reg;
                prod_next = $unsigned(mul_res);
            end
            S_SQ_SUM:
            begin
                rsq_next    = hsq_reg + prod_reg;
                rad_next    = hsq_reg + prod_reg;
                root_next   = '0;
                rem_next    = '0;
                sqrt_h_next = 1'b0;
                cnt_next    = SQRT_LAST;
            end
            S_SQRT:
            begin
                rem_next  = sq_bit ? REMW'(sq_rem_t - sq_trial) : REMW'(sq_rem_t);
                root_next = sq_root;
                rad_next  = {rad_reg[SQW-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (!sqrt_h_reg)
                    begin
                        range_next = sq_root[RTW-1] ? RANGE_MAX : sq_root[23:0];
                    end
                    else
                    begin
                        cord_azi_next = 1'b0;
                        cnt_next      = '0;
                        if (ld_x < 0)
                        begin
                            cx_next = -ld_x;
                            cy_next = -ld_y;
                            cz_next = ANG180;
                        end
                        else
                        begin
                            cx_next = ld_x;
                            cy_next = ld_y;
                            cz_next = '0;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if ((rsq_reg == '0) || (rsq_reg < SQW'(cfg.min_sq)))
                begin
                    stat_next = RES_NEAR;
                end
                else if (cfg.limit && (hsq_reg > SQW'(cfg.max_sq)))
                begin
                    stat_next = RES_FAR;
                end
                else
                begin
                    rad_next      = hsq_reg;
                    root_next     = '0;
                    rem_next      = '0;
                    sqrt_h_next   = 1'b1;
                    cord_azi_next = 1'b0;
                    cnt_next      = SQRT_LAST;
                end
            end
            S_NORM:
            begin
                if (norm_go)
                begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                end
                cnt_next = '0;
            end
            S_ROTATE:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_entry(cnt_reg);
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_entry(cnt_reg);
                end
                cnt_next = cnt_reg + 1'b1;
            end
            S_ANGLE:
            begin
                if (!cord_azi_reg)
                begin
                    zcode_next = zen_clamp[CODEW+7:8];
                    if (vertical)
                    begin
                        acode_next = AZI_VERT_CODE;
                        dq_next    = zen_clamp[CODEW+7:8];
                        drem_next  = '0;
                        ddiv_next  = cfg.zenith_step;
                        dsel_next  = DIV_ROW;
                        cnt_next   = DIV_LAST;
                    end
                    else
                    begin
                        cord_azi_next = 1'b1;
                        if (CXW'(dy_reg) < 0)
                        begin
                            cx_next = -CXW'(dy_reg);
                            cy_next = -CXW'(dx_reg);
                            cz_next = ANG180;
                        end
                        else
                        begin
                            cx_next = CXW'(dy_reg);
                            cy_next = CXW'(dx_reg);
                            cz_next = '0;
                        end
                        cnt_next = '0;
                    end
                end
                else
                begin
                    acode_next = azi_wrap[CODEW+7:8];
                    dq_next    = zcode_reg;
                    drem_next  = '0;
                    ddiv_next  = cfg.zenith_step;
                    dsel_next  = DIV_ROW;
                    cnt_next   = DIV_LAST;
                end
            end
            S_DIV:
            begin
                if (dsel_reg == DIV_GREY)
                begin
                    grey_next = grey_prod[GREY_SHIFT+7:GREY_SHIFT];
                end
                else
                begin
                    drem_next = dv_bit ? CODEW'(dv_rem_t - {1'b0, ddiv_reg})
                                       : dv_rem_t[CODEW-1:0];
                    dq_next   = dv_quot;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        case (dsel_reg)
                            DIV_ROW:
                            begin
                                row_next  = (dv_quot > CODEW'(ROWS - 1))
                                          ? RW'(ROWS - 1) : dv_quot[RW-1:0];
                                dq_next   = acode_reg;
                                drem_next = '0;
                                ddiv_next = cfg.azimuth_step;
                                dsel_next = DIV_COL;
                                cnt_next  = DIV_LAST;
                            end
                            default:
                            begin
                                col_next = (dv_quot > CODEW'(COLUMNS - 1))
                                         ? CW'(COLUMNS - 1) : CW'(dv_quot);
                            end
                        endcase
                    end
                end
            end
            S_INDEX:
            begin
                bidx_next = AW'(AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg));
            end
            S_BIN_UPD:
            begin
                idx_next = 16'(bidx_reg);
                if (!ram_rdata[BW-1] && (row_reg < RW'(ROWS / 2)) && (empty_reg != '0))
                begin
                    empty_next = empty_reg - 1'b1;
                end
            end
            S_READ_RD:
            begin
                idx_next = ri_reg;
            end
            S_READ_CHK:
            begin
                if (ram_rdata[BW-1])
                begin
                    range_next  = ram_rdata[23:0];
                    filled_next = 1'b1;
                    dq_next     = grey_cap;
                    dsel_next   = DIV_GREY;
                end
            end
            S_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(NBINS - 1))
                begin
                    empty_next = EW'(UPPER);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = stat_reg;
                    out_data_next  = {15'(empty_reg), grey_reg, filled_reg, range_reg,
                                      idx_reg};
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            empty_reg     <= EW'(UPPER);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dz_reg       <= dz_next;
        ri_reg       <= ri_next;
        prod_reg     <= prod_next;
        hsq_reg      <= hsq_next;
        rsq_reg      <= rsq_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        sqrt_h_reg   <= sqrt_h_next;
        cnt_reg      <= cnt_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        cord_azi_reg <= cord_azi_next;
        zcode_reg    <= zcode_next;
        acode_reg    <= acode_next;
        dq_reg       <= dq_next;
        drem_reg     <= drem_next;
        ddiv_reg     <= ddiv_next;
        dsel_reg     <= dsel_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        bidx_reg     <= bidx_next;
        stat_reg     <= stat_next;
        idx_reg      <= idx_next;
        range_reg    <= range_next;
        filled_reg   <= filled_next;
        grey_reg     <= grey_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
class depth_bin_scoreboard;
    localparam int ROWS = 180;
    localparam int COLUMNS = 360;
    localparam int NBINS = ROWS * COLUMNS;
    localparam int UPPER = (ROWS / 2) * COLUMNS;

    logic signed [63:0] vx, vy, vz;
    logic [23:0] min_dist, max_hor;
    logic limit_on;
    logic [16:0] zen_step, azi_step;
    logic [23:0] bin_rng [NBINS];
    bit bin_set [NBINS];
    int unsigned empty_up;
    logic [66:0] expected_words [$];
    int errors;

    function new();
        vx = 0; vy = 0; vz = 0;
        min_dist = 0; max_hor = 100000; limit_on = 1;
        zen_step = 256; azi_step = 256;
        foreach (bin_set[i]) bin_set[i] = 0;
        empty_up = UPPER;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
        case (idx)
            sdb_pkg::REG_VIEW_X:   vx = $signed(d);
            sdb_pkg::REG_VIEW_Y:   vy = $signed(d);
            sdb_pkg::REG_VIEW_Z:   vz = $signed(d);
            sdb_pkg::REG_MIN_DIST: min_dist = d;
            sdb_pkg::REG_MAX_HOR:  max_hor = d;
            sdb_pkg::REG_LIMIT:    limit_on = d[0];
            sdb_pkg::REG_ZEN_STEP: zen_step = {1'b0, d[15:0]};
            default:               azi_step = d[16:0];
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function longint angle_of(longint y, longint x);
        longint base, z, xs, ys;
        base = 0; z = 0;
        if (x < 0)
        begin
            x = -x; y = -y; base = sdb_pkg::ANG180;
        end
        if (x == 0 && y == 0) return base;
        while ((x < 0 ? -x : x) < (64'sd1 << 29) && (y < 0 ? -y : y) < (64'sd1 << 29))
        begin
            x *= 2; y *= 2;
        end
        for (int i = 0; i < 20; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += sdb_pkg::atan_entry(5'(i));
            end
            else
            begin
                x -= ys; y += xs; z -= sdb_pkg::atan_entry(5'(i));
            end
        end
        return base + z;
    endfunction

    function void note_word(logic [1:0] cmd, logic [87:0] d);
        logic [2:0] st;
        logic [15:0] idx;
        logic [23:0] rng;
        logic fil;
        logic [7:0] grey;
        longint dx, dy, dz, zen, azi, h;
        longint unsigned hsq, rsq, r, row, col, b, zs, as, dd;
        st = 0; idx = 0; rng = 0; fil = 0; grey = 0;
        case (cmd)
            sdb_pkg::CMD_CLEAR:
            begin
                foreach (bin_set[i]) bin_set[i] = 0;
                empty_up = UPPER;
                st = sdb_pkg::RES_CLEARED;
            end
            sdb_pkg::CMD_ADD:
            begin
                dx = longint'($signed(d[23:0])) - vx;
                dy = longint'($signed(d[47:24])) - vy;
                dz = longint'($signed(d[71:48])) - vz;
                hsq = dx * dx + dy * dy;
                rsq = hsq + dz * dz;
                r = int_sqrt(rsq);
                rng = r > 24'hFFFFFF ? 24'hFFFFFF : r[23:0];
                if (rsq == 0 || rsq < longint'(min_dist) * min_dist)
                    st = sdb_pkg::RES_NEAR;
                else if (limit_on && hsq > longint'(max_hor) * max_hor)
                    st = sdb_pkg::RES_FAR;
                else
                begin
                    h = int_sqrt(hsq);
                    zen = angle_of(h, dz);
                    if (zen < 0) zen = 0;
                    if (dx == 0 && dy == 0) azi = 90 * 65536;
                    else azi = angle_of(dx, dy);
                    if (azi < 0) azi += 360 * 65536;
                    if (azi >= 360 * 65536) azi -= 360 * 65536;
                    zs = zen_step == 0 ? 1 : zen_step;
                    as = azi_step == 0 ? 1 : azi_step;
                    row = (zen >> 8) / zs;
                    col = (azi >> 8) / as;
                    if (row > ROWS - 1) row = ROWS - 1;
                    if (col > COLUMNS - 1) col = COLUMNS - 1;
                    b = row * COLUMNS + col;
                    if (!bin_set[b])
                    begin
                        bin_set[b] = 1;
                        bin_rng[b] = rng;
                        if (row < ROWS / 2 && empty_up > 0) empty_up--;
                    end
                    else if (rng < bin_rng[b])
                        bin_rng[b] = rng;
                    idx = b[15:0];
                    st = sdb_pkg::RES_BINNED;
                end
            end
            sdb_pkg::CMD_READ:
            begin
                st = sdb_pkg::RES_READ;
                idx = d[87:72];
                if (idx < NBINS && bin_set[idx])
                begin
                    rng = bin_rng[idx];
                    dd = rng > min_dist ? rng - min_dist : 0;
                    if (dd > 100000) dd = 100000;
                    fil = 1;
                    grey = 8'(dd * 200 / 100000);
                end
            end
            default: st = sdb_pkg::RES_COUNT;
        endcase
        expected_words.push_back({st, empty_up[14:0], grey, fil, rng, idx});
    endfunction

    function void check_word(logic [2:0] st, logic [63:0] d);
        logic [66:0] e;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word status %0d data %h", $time, st, d);
            errors++;
            return;
        end
        e = expected_words.pop_front();
        if (e[66:64] !== st || e[63:0] !== d)
        begin
            $display("%0t: expected status %0d data %h, actual status %0d data %h",
                     $time, e[66:64], e[63:0], st, d);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import sdb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [23:0] cfg_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [87:0] s_tdata = 0;
    logic [1:0] s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic [2:0] m_tuser;

    int send_idle, recv_idle;
    depth_bin_scoreboard sb = new();

    spherical_depth_binning_core dut (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata);

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic send_word(cmd_t cmd, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic [15:0] ri);
        cfg_we <= 0;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {ri, z, y, x};
        do @(posedge clk); while (!s_tready);
        sb.note_word(cmd, {ri, z, y, x});
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.expected_words.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_reg(cfg_reg_t idx, logic [23:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    function automatic logic [23:0] coord(int spread);
        case ($urandom_range(3))
            0: return 24'($signed($urandom_range(2 * spread)) - spread);
            1: return 24'($urandom);
            2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic random_phase(int n, int spread);
        cmd_t c;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            c = k < 75 ? CMD_ADD : k < 92 ? CMD_READ : k < 97 ? CMD_QUERY : CMD_CLEAR;
            send_word(c, coord(spread), coord(spread), coord(spread),
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64799)));
        end
    endtask

    initial
    begin
        #500ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        send_idle = 15;
        recv_idle = 72;
        repeat (8) @(negedge clk);
        rst_n = 1;
        send_word(CMD_QUERY, 0, 0, 0, 0);
        send_word(CMD_ADD, 0, 0, 0, 0);
        send_word(CMD_ADD, 0, 0, 1000, 0);
        send_word(CMD_ADD, 0, 0, -1000, 0);
        send_word(CMD_ADD, 5000, 0, 0, 0);
        send_word(CMD_ADD, 0, -5000, 100, 0);
        send_word(CMD_ADD, -3000, -3000, -10, 0);
        send_word(CMD_ADD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
        send_word(CMD_ADD, 24'h800000, 24'h800000, 24'h800000, 0);
        send_word(CMD_ADD, 100, 200, 300, 0);
        send_word(CMD_ADD, 90, 200, 300, 0);
        send_word(CMD_READ, 0, 0, 0, 90 * 360);
        send_word(CMD_READ, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 64799);
        send_word(CMD_READ, 0, 0, 0, 16'hFFFF);
        send_word(CMD_QUERY, 0, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 90 * 360);
        random_phase(400, 50000);
        drain();
        set_reg(REG_VIEW_X, 24'h800000);
        set_reg(REG_VIEW_Y, 24'h7FFFFF);
        set_reg(REG_VIEW_Z, 24'd1234);
        set_reg(REG_MIN_DIST, 24'd500);
        set_reg(REG_MAX_HOR, 24'hFFFFFF);
        set_reg(REG_LIMIT, 24'd0);
        set_reg(REG_ZEN_STEP, 24'd0);
        set_reg(REG_AZI_STEP, 24'd92160);
        send_idle = 72;
        recv_idle = 15;
        random_phase(500, 8000000);
        drain();
        set_reg(REG_VIEW_X, 0);
        set_reg(REG_VIEW_Y, 0);
        set_reg(REG_VIEW_Z, 0);
        set_reg(REG_MIN_DIST, 24'hFFFFFF);
        set_reg(REG_LIMIT, 24'd1);
        set_reg(REG_MAX_HOR, 24'd0);
        set_reg(REG_ZEN_STEP, 24'd46080);
        set_reg(REG_AZI_STEP, 24'd1);
        random_phase(100, 8000000);
        drain();
        set_reg(REG_MIN_DIST, 24'd50);
        set_reg(REG_MAX_HOR, 24'd60000);
        set_reg(REG_ZEN_STEP, 24'd512);
        set_reg(REG_AZI_STEP, 24'd700);
        send_idle = 0;
        recv_idle = 0;
        random_phase(800, 60000);
        drain();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
